>>> hdl/ecsa_pkg.sv
// Shared types and constants for the expert cache slot assignment block.
// No dependencies; every other file in hdl/ except ecsa_ram imports this package.
package ecsa_pkg;

   localparam int LAYER_W  = 6;
   localparam int EXPERT_W = 10;
   localparam int SLOT_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int PTR_W    = 9;
   localparam int MAP_W    = 9;   // valid bit on top of an 8-bit slot
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [8:0] SLOTS_RESET    = 9'd256;
   localparam logic [7:0] RESIDENT_RESET = 8'd128;
   localparam logic [8:0] EXPERTS_RESET  = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDENT_SLOTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPERT_COUNT   = 2'd2;

   typedef enum logic [1:0] {
      ACT_SKIP      = 2'd0,
      ACT_HIT       = 2'd1,
      ACT_NEW       = 2'd2,
      ACT_TRANSIENT = 2'd3
   } action_type;

   // Decision of one lookup: write-back requests and the result word.
   typedef struct packed {
      logic               map_we;
      logic [MAP_W-1:0]   map_wdata;
      logic               cnt_we;
      logic [COUNT_W-1:0] cnt_wdata;
      logic [SLOT_W-1:0]  slot;
      action_type         action;
   } assign_res_type;

   typedef struct packed {
      logic active;
      logic done;
   } clr_status_type;

endpackage

>>> hdl/expert_cache_slot_assign.sv
// Top level: stream ports, configuration registers, lookup sequencer, RAMs.
// Depends on ecsa_pkg, ecsa_ram, ecsa_clear and ecsa_assign.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata: layer, expert_id; tuser: batch_start
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: slot, echo_expert, echo_layer; tuser: action
//  csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// The map and count RAMs are read on the accept edge and the decision and write-back
// happen on the edge where the lookup fires, which a stalled rsp side can delay, so
// one id is in flight. After reset a clear sweep zeroes the map and the layer counts;
// no word is accepted until it ends.
// The result sits in an output register; a stalled rsp side holds the lookup.
module expert_cache_slot_assign #(
   parameter int MAX_LAYERS  = 64,
   parameter int MAX_EXPERTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [5:0] layer, [15:6] expert_id
   input  logic                               req_tuser,   // [0] batch_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // [7:0] slot, [17:8] echo_expert,
                                                           // [23:18] echo_layer
   output logic [1:0]                         rsp_tuser,   // [1:0] action
   input  logic                               csr_wr_en,
   input  logic [ecsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ecsa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ecsa_pkg::*;

   localparam int MAP_DEPTH = MAX_LAYERS * MAX_EXPERTS;
   localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int CNT_AW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'b001,
      S_IDLE   = 3'b010,
      S_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [8:0] slots_ff;
   logic [7:0] resident_ff;
   logic [8:0] experts_ff;

   logic [LAYER_W-1:0]  req_layer;
   logic [EXPERT_W-1:0] req_id;
   logic                req_in_range;
   logic [17:0]         map_addr_wide;
   logic [7:0]          layer_ext;
   logic [MAP_AW-1:0]   map_rd_addr;
   logic [CNT_AW-1:0]   cnt_rd_addr;
   logic                accept;
   logic                fire;

   logic [LAYER_W-1:0]  layer_ff;
   logic [EXPERT_W-1:0] id_ff;
   logic                start_ff;
   logic                in_range_ff;
   logic [MAP_AW-1:0]   map_addr_ff;
   logic [CNT_AW-1:0]   cnt_addr_ff;

   logic [MAP_AW-1:0]   clr_addr;
   clr_status_type      clr;
   logic                clr_cnt_hit;

   logic                map_we;
   logic [MAP_AW-1:0]   map_waddr;
   logic [MAP_W-1:0]    map_wdata;
   logic [MAP_W-1:0]    map_rd;
   logic                cnt_we;
   logic [CNT_AW-1:0]   cnt_waddr;
   logic [COUNT_W-1:0]  cnt_wdata;
   logic [COUNT_W-1:0]  cnt_rd;

   assign_res_type      res;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   action_type          rsp_action_ff;
   logic [EXPERT_W-1:0] rsp_expert_ff;
   logic [LAYER_W-1:0]  rsp_layer_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff    <= SLOTS_RESET;
         resident_ff <= RESIDENT_RESET;
         experts_ff  <= EXPERTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SLOTS_IN_USE:   slots_ff    <= csr_wdata;
            CSR_RESIDENT_SLOTS: resident_ff <= csr_wdata[7:0];
            CSR_EXPERT_COUNT:   experts_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request decode and RAM read addresses.
   assign req_layer    = req_tdata[LAYER_W-1:0];
   assign req_id       = req_tdata[LAYER_W +: EXPERT_W];
   assign req_in_range = (9'(req_layer) < 9'(MAX_LAYERS))
                         && (11'(req_id) < 11'(experts_ff))
                         && (11'(req_id) < 11'(MAX_EXPERTS));
   assign map_addr_wide = 18'(req_layer) * 18'(MAX_EXPERTS) + 18'(req_id);
   assign layer_ext     = 8'(req_layer);
   assign map_rd_addr   = req_in_range ? map_addr_wide[MAP_AW-1:0] : '0;
   assign cnt_rd_addr   = req_in_range ? layer_ext[CNT_AW-1:0] : '0;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign fire       = (state_ff == S_LOOKUP) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr.done) state_in = S_IDLE;
         S_IDLE:   if (accept) state_in = S_LOOKUP;
         S_LOOKUP: if (fire) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         layer_ff    <= req_layer;
         id_ff       <= req_id;
         start_ff    <= req_tuser;
         in_range_ff <= req_in_range;
         map_addr_ff <= map_rd_addr;
         cnt_addr_ff <= cnt_rd_addr;
      end
   end

   ecsa_clear #(
      .DEPTH (MAP_DEPTH),
      .AW    (MAP_AW)
   ) u_clear (
      .clock  (clock),
      .reset  (reset),
      .addr   (clr_addr),
      .status (clr)
   );

   assign clr_cnt_hit = (19'(clr_addr) < 19'(MAX_LAYERS));

   // The sweep owns both write ports until it finishes.
   always_comb begin
      if (clr.active) begin
         map_we    = 1'b1;
         map_waddr = clr_addr;
         map_wdata = '0;
         cnt_we    = clr_cnt_hit;
         cnt_waddr = clr_addr[CNT_AW-1:0];
         cnt_wdata = '0;
      end else begin
         map_we    = res.map_we;
         map_waddr = map_addr_ff;
         map_wdata = res.map_wdata;
         cnt_we    = res.cnt_we;
         cnt_waddr = cnt_addr_ff;
         cnt_wdata = res.cnt_wdata;
      end
   end

   ecsa_ram #(
      .DEPTH (MAP_DEPTH),
      .WIDTH (MAP_W),
      .AW    (MAP_AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (accept),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd)
   );

   ecsa_ram #(
      .DEPTH (MAX_LAYERS),
      .WIDTH (COUNT_W),
      .AW    (CNT_AW)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (accept),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd)
   );

   ecsa_assign u_assign (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .in_range       (in_range_ff),
      .batch_start    (start_ff),
      .slots_in_use   (slots_ff),
      .resident_slots (resident_ff),
      .map_rd         (map_rd),
      .cnt_rd         (cnt_rd),
      .res            (res)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_slot_ff   <= res.slot;
         rsp_action_ff <= res.action;
         rsp_expert_ff <= id_ff;
         rsp_layer_ff  <= layer_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_layer_ff, rsp_expert_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_action_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr.active |-> !req_tready)
      else $error("word accepted during map clear");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted word did not enter lookup");

   a_map_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      res.map_we |-> (state_ff == S_LOOKUP) && fire && !clr.active)
      else $error("map write outside a completing lookup");

   a_new_below_quota: assert property (@(posedge clock) disable iff (reset)
      (fire && res.action == ACT_NEW) |-> (cnt_rd < COUNT_W'(resident_ff)))
      else $error("new resident slot at or above quota");

   a_fire_loads_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("completed lookup left no result");
`endif

endmodule

>>> hdl/ecsa_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Depends on nothing; used for the resident map and the per-layer counts.
module ecsa_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 9,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ecsa_clear.sv
// Post-reset sweep that walks every map address once so it can be zeroed.
// Depends on ecsa_pkg.
module ecsa_clear #(
   parameter int DEPTH = 16384,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic [AW-1:0]           addr,
   output ecsa_pkg::clr_status_type status
);
   import ecsa_pkg::*;

   logic          active_ff, active_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          last;

   assign last = (addr_ff == AW'(DEPTH - 1));

   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (active_ff) begin
         addr_in = addr_ff + AW'(1);
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   assign addr          = addr_ff;
   assign status.active = active_ff;
   assign status.done   = active_ff & last;

endmodule

>>> hdl/ecsa_assign.sv
// Slot decision for one looked-up id, plus the round-robin transient pointer.
// Depends on ecsa_pkg; fed by the map and count RAM read ports.
module ecsa_assign (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic                            in_range,
   input  logic                            batch_start,
   input  logic [8:0]                      slots_in_use,
   input  logic [7:0]                      resident_slots,
   input  logic [ecsa_pkg::MAP_W-1:0]      map_rd,
   input  logic [ecsa_pkg::COUNT_W-1:0]    cnt_rd,
   output ecsa_pkg::assign_res_type        res
);
   import ecsa_pkg::*;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] ptr_start, ptr_wrap;
   logic [PTR_W-1:0] quota;

   assign quota     = PTR_W'(resident_slots);
   assign ptr_start = batch_start ? quota : ptr_ff;
   assign ptr_wrap  = (ptr_start >= slots_in_use) ? quota : ptr_start;

   always_comb begin
      res           = '0;
      res.action    = ACT_SKIP;
      res.map_wdata = {1'b1, cnt_rd[SLOT_W-1:0]};
      res.cnt_wdata = cnt_rd + COUNT_W'(1);
      ptr_in        = ptr_start;
      if (in_range) begin
         if (map_rd[MAP_W-1]) begin
            res.slot   = map_rd[SLOT_W-1:0];
            res.action = ACT_HIT;
         end else if (cnt_rd < COUNT_W'(resident_slots)) begin
            // The count stays below an 8-bit quota, so it fits the slot field.
            res.slot   = cnt_rd[SLOT_W-1:0];
            res.action = ACT_NEW;
            res.map_we = fire;
            res.cnt_we = fire;
         end else begin
            res.slot   = ptr_wrap[SLOT_W-1:0];
            res.action = ACT_TRANSIENT;
            ptr_in     = ptr_wrap + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= PTR_W'(RESIDENT_RESET);
      end else if (fire) begin
         ptr_ff <= ptr_in;
      end
   end

endmodule

>>> verif/tb_expert_cache_slot_assign.sv
// Testbench for expert_cache_slot_assign: drives id words on the req stream,
// predicts slot and action per layer, and checks every rsp word in order.
// Depends on ecsa_pkg and the RTL of expert_cache_slot_assign.
`timescale 1ns / 100ps

module tb_expert_cache_slot_assign;
   import ecsa_pkg::*;

   localparam int NUM_LAYERS  = 64;
   localparam int NUM_EXPERTS = 256;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      action_type          action;
      logic [EXPERT_W-1:0] expert;
      logic [LAYER_W-1:0]  layer;
   } slot_result_t;

   // Tracks the per-layer resident tables and the transient pointer, and
   // compares each returned word with the oldest predicted one.
   class slot_tracker;
      logic [MAP_W-1:0]   resident_map [NUM_LAYERS][NUM_EXPERTS];
      logic [COUNT_W-1:0] resident_count [NUM_LAYERS];
      logic [PTR_W-1:0]   transient_ptr;
      logic [8:0]         slots_cfg;
      logic [7:0]         quota_cfg;
      logic [8:0]         experts_cfg;
      slot_result_t       expected_slots[$];
      int                 mismatches;
      int                 action_seen[4];

      function new();
         foreach (resident_map[l, e]) resident_map[l][e] = '0;
         foreach (resident_count[l]) resident_count[l] = '0;
         slots_cfg     = SLOTS_RESET;
         quota_cfg     = RESIDENT_RESET;
         experts_cfg   = EXPERTS_RESET;
         transient_ptr = {1'b0, RESIDENT_RESET};
         mismatches    = 0;
         foreach (action_seen[a]) action_seen[a] = 0;
      endfunction

      function void set_config(logic [8:0] slots, logic [7:0] quota, logic [8:0] experts);
         slots_cfg   = slots;
         quota_cfg   = quota;
         experts_cfg = experts;
      endfunction

      function void note_request(logic [LAYER_W-1:0] layer, logic [EXPERT_W-1:0] id,
                                 logic start);
         slot_result_t     res;
         logic [MAP_W-1:0] entry;
         res.slot   = '0;
         res.action = ACT_SKIP;
         res.expert = id;
         res.layer  = layer;
         if (start)
            transient_ptr = {1'b0, quota_cfg};
         if (id < experts_cfg && id < NUM_EXPERTS) begin
            entry = resident_map[layer][id];
            if (entry[MAP_W-1]) begin
               res.slot   = entry[SLOT_W-1:0];
               res.action = ACT_HIT;
            end else if (resident_count[layer] < quota_cfg) begin
               res.slot   = resident_count[layer][SLOT_W-1:0];
               res.action = ACT_NEW;
               resident_count[layer] = resident_count[layer] + 1'b1;
               resident_map[layer][id] = {1'b1, res.slot};
            end else begin
               // The wrap check uses the full 9-bit pointer; only the low byte is reported.
               if (transient_ptr >= slots_cfg)
                  transient_ptr = {1'b0, quota_cfg};
               res.slot      = transient_ptr[SLOT_W-1:0];
               res.action    = ACT_TRANSIENT;
               transient_ptr = transient_ptr + 1'b1;
            end
         end
         expected_slots.insert(expected_slots.size(), res);
      endfunction

      function void check_result(slot_result_t got);
         slot_result_t want;
         if (expected_slots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected word slot=%0d action=%s expert=%0d layer=%0d",
                        got.slot, got.action.name(), got.expert, got.layer);
            return;
         end
         want = expected_slots.pop_front();
         action_seen[want.action]++;
         if (got.slot !== want.slot || got.action !== want.action ||
             got.expert !== want.expert || got.layer !== want.layer) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: L%0d E%0d: want slot=%0d %s, got slot=%0d %s E%0d L%0d",
                        want.layer, want.expert, want.slot, want.action.name(),
                        got.slot, got.action.name(), got.expert, got.layer);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   slot_tracker tracker = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int random_sent   = 0;
   int settings_used = 1;

   localparam int RANDOM_WORDS = 880;

   expert_cache_slot_assign u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: a requested hold-off is counted here, otherwise random stalls.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Both handshakes are judged on the values present at the edge.
   always @(posedge clock) begin
      slot_result_t got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.slot   = rsp_tdata[7:0];
            got.expert = rsp_tdata[17:8];
            got.layer  = rsp_tdata[23:18];
            got.action = action_type'(rsp_tuser);
            tracker.check_result(got);
         end
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[5:0], req_tdata[15:6], req_tuser);
      end
   end

   task automatic send_word(input logic [LAYER_W-1:0] layer, input logic [EXPERT_W-1:0] id,
                            input logic start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {id, layer};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_slots.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [8:0] slots, input logic [7:0] quota,
                               input logic [8:0] experts);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SLOTS_IN_USE;
      csr_wdata <= slots;
      @(posedge clock);
      csr_index <= CSR_RESIDENT_SLOTS;
      csr_wdata <= {1'b0, quota};
      @(posedge clock);
      csr_index <= CSR_EXPERT_COUNT;
      csr_wdata <= experts;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_config(slots, quota, experts);
      settings_used++;
   endtask

   function automatic logic [EXPERT_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return EXPERT_W'($urandom_range(15));
      else if (r < 90)
         return EXPERT_W'($urandom_range(tracker.experts_cfg + 2));
      return EXPERT_W'($urandom_range(1023));
   endfunction

   // Sender and receiver swap idle rates a third of the way in, then both stop idling.
   function automatic void update_idling();
      case (random_sent * 3 / RANDOM_WORDS)
         0: begin
            send_idle_pct = 36;
            recv_idle_pct = 59;
         end
         1: begin
            send_idle_pct = 59;
            recv_idle_pct = 36;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endfunction

   // Mostly batches on a few hot layers so quotas fill up; one pick in ten is a single noise word.
   task automatic run_random(input int n_words);
      int sent;
      int len;
      logic [LAYER_W-1:0] lyr;
      sent = 0;
      while (sent < n_words) begin
         update_idling();
         if ($urandom_range(9) == 0) begin
            send_word(LAYER_W'($urandom_range(63)), EXPERT_W'($urandom_range(1023)),
                      1'($urandom_range(1)));
            sent++;
            random_sent++;
         end else begin
            len = $urandom_range(1, 8);
            lyr = ($urandom_range(4) == 0) ? LAYER_W'($urandom_range(63))
                                           : LAYER_W'($urandom_range(3));
            for (int k = 0; k < len; k++) begin
               send_word(lyr, pick_id(), k == 0);
               sent++;
               random_sent++;
            end
         end
      end
      drain();
   endtask

   initial begin
      #5_000_000;
      $display("FAIL expert_cache_slot_assign");
      $finish;
   end

   initial begin
      int words;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default settings: hits, new residents, ids past the table, batch start on a skip.
      send_word(6'd0, 10'd0, 1'b1);
      send_word(6'd0, 10'd0, 1'b0);
      send_word(6'd0, 10'd255, 1'b0);
      send_word(6'd0, 10'd256, 1'b0);
      send_word(6'd0, 10'd1023, 1'b1);
      send_word(6'd63, 10'd0, 1'b0);
      send_word(6'd63, 10'd1023, 1'b0);
      send_word(6'd63, 10'd0, 1'b1);
      send_word(6'd42, 10'd512, 1'b0);
      send_word(6'd21, 10'h155, 1'b0);
      drain();

      // Small quota: transient round robin, wrap, batch restart, id past expert_count.
      write_config(9'd4, 8'd2, 9'd8);
      send_word(6'd5, 10'd0, 1'b1);
      send_word(6'd5, 10'd1, 1'b0);
      send_word(6'd5, 10'd2, 1'b0);
      send_word(6'd5, 10'd3, 1'b0);
      send_word(6'd5, 10'd4, 1'b0);
      send_word(6'd5, 10'd5, 1'b1);
      send_word(6'd5, 10'd8, 1'b0);
      send_word(6'd5, 10'd7, 1'b0);
      send_word(6'd5, 10'd0, 1'b0);
      drain();

      // Quota equal to the slot count: every transient wraps to the quota.
      write_config(9'd2, 8'd2, 9'd8);
      send_word(6'd5, 10'd6, 1'b0);
      send_word(6'd5, 10'd6, 1'b0);
      drain();

      // No resident quota at all.
      write_config(9'd10, 8'd0, 9'd8);
      send_word(6'd7, 10'd3, 1'b1);
      send_word(6'd7, 10'd3, 1'b0);
      drain();

      // Park the pointer at 250, then widen the slot count past 256 so the
      // reported slot is only the low byte of the pointer.
      write_config(9'd256, 8'd250, 9'd256);
      send_word(6'd62, 10'd1023, 1'b1);
      drain();
      write_config(9'd320, 8'd1, 9'd256);
      for (int i = 0; i < 80; i++)
         send_word(6'd62, EXPERT_W'(i), 1'b0);
      drain();

      write_config(9'd8, 8'd4, 9'd32);
      hold_request = 200;
      run_random(110);
      write_config(9'd2, 8'd1, 9'd1);
      run_random(110);
      write_config(9'd16, 8'd20, 9'd64);
      run_random(110);
      write_config(9'd256, 8'd255, 9'd256);
      run_random(110);
      write_config(9'd12, 8'd0, 9'd200);
      run_random(110);
      write_config(9'd40, 8'd16, 9'd100);
      run_random(110);
      write_config(9'd256, 8'd128, 9'd256);
      run_random(110);
      write_config(9'd5, 8'd2, 9'd3);
      run_random(110);

      repeat (8) @(posedge clock);
      words = 0;
      foreach (tracker.action_seen[a]) words += tracker.action_seen[a];
      $display("Checked %0d result words over %0d register settings.", words, settings_used);
      $display("Actions seen: %0d skipped, %0d hits, %0d new residents, %0d transient loads.",
               tracker.action_seen[ACT_SKIP], tracker.action_seen[ACT_HIT],
               tracker.action_seen[ACT_NEW], tracker.action_seen[ACT_TRANSIENT]);
      if (tracker.mismatches == 0 && tracker.expected_slots.size() == 0) begin
         $display("PASS expert_cache_slot_assign");
      end else begin
         $display("Mismatches: %0d, words still expected: %0d",
                  tracker.mismatches, tracker.expected_slots.size());
         $display("FAIL expert_cache_slot_assign");
      end
      $finish;
   end

endmodule
